### sv/hta_pkg.sv
// shared constants, codes and the helper function of the handle table allocator
`timescale 1ns / 1ps

package hta_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam logic [7:0] KEEP_MASK_RESET = 8'h01;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 96;

    // operation codes
    localparam logic [2:0] OP_ADD_AUTO  = 3'd0;
    localparam logic [2:0] OP_ADD_AT    = 3'd1;
    localparam logic [2:0] OP_RESERVE   = 3'd2;
    localparam logic [2:0] OP_UNRESERVE = 3'd3;
    localparam logic [2:0] OP_ALLOC_RES = 3'd4;
    localparam logic [2:0] OP_REMOVE    = 3'd5;
    localparam logic [2:0] OP_RESOLVE   = 3'd6;
    localparam logic [2:0] OP_PURGE     = 3'd7;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BAD  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // lowest set bit of a bitmap word, 63 when none is set
    function automatic logic [5:0] low_bit(input logic [63:0] v);
        logic [5:0] n;
        n = 6'd63;
        for (int k = 63; k >= 0; k--) begin
            if (v[k]) n = 6'(k);
        end
        return n;
    endfunction

endpackage

### sv/handle_table_allocator.sv
// handle table allocator: occupancy bitmap, entry store and operation sequencer
`timescale 1ns / 1ps

// Descriptor table of CAPACITY entries with a 64-bit-word occupancy bitmap. One
// word in, one result word out; the block takes a new word only while its
// sequencer is idle, and a finished result may wait at the output meanwhile.
// Each word is paced by the single bitmap read port and the single entry port:
// reserve and unreserve go straight to the result; add_at, remove and resolve
// check the handle's bitmap bit and entry; add_auto and alloc_reserved scan the
// bitmap upward word by word; purge walks every entry one per cycle.
// After reset a clearing pass zeroes the bitmap before the first word is taken;
// configuration writes are taken at any time.
module handle_table_allocator #(
    parameter int CAPACITY = hta_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [7:0]                   i_cfg_wr_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // operation, handle_index, has_remove_right, object_id, entry_rights,
    // entry_flags, zero fill
    input  logic [hta_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // status, result_handle, replaced, resolved_object, resolved_rights,
    // resolved_flags, purged_count
    output logic [hta_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import hta_pkg::*;

    localparam int WORDS   = (CAPACITY + 63) / 64;
    localparam int WW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int ENTRIES = WORDS * 64;
    localparam int IW      = $clog2(ENTRIES);
    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int XW      = (IW + 1 > 11) ? IW + 1 : 11;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_HCHK = 4'd3;
    localparam logic [3:0] S_PLD  = 4'd4;
    localparam logic [3:0] S_PENT = 4'd5;
    localparam logic [3:0] S_PWB  = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    localparam logic [WW-1:0] LAST_WORD = WW'(WORDS - 1);
    localparam logic [XW-1:0] CAP_X     = XW'(CAPACITY);

    logic [3:0]    r_state, n_state;
    logic [WW-1:0] r_w, n_w;
    logic [5:0]    r_b, n_b;
    logic          r_first, n_first;
    logic [2:0]    r_op, n_op;
    logic [IW-1:0] r_h, n_h;
    logic          r_right, n_right;
    logic [31:0]   r_obj, n_obj;
    logic [31:0]   r_rts, n_rts;
    logic [7:0]    r_flg, n_flg;
    logic          r_full, n_full;
    logic [63:0]   r_word, n_word;
    logic [CW-1:0] r_hint, n_hint;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_resv, n_resv;
    logic [CW-1:0] r_pc, n_pc;
    logic [1:0]    r_sta, n_sta;
    logic [9:0]    r_hdl, n_hdl;
    logic          r_rep, n_rep;
    logic [31:0]   r_robj, n_robj;
    logic [31:0]   r_rrts, n_rrts;
    logic [7:0]    r_rflg, n_rflg;
    logic          r_mvalid, n_mvalid;
    logic [M_TDATA_W-1:0] r_mdata, n_mdata;
    logic [7:0]    r_keep;

    logic [63:0]   bm_mem [WORDS];
    logic [71:0]   ent_mem [ENTRIES];
    logic [63:0]   r_bm_q;
    logic [71:0]   r_ent_q;

    logic          bm_we;
    logic [WW-1:0] bm_waddr;
    logic [63:0]   bm_wdata;
    logic          ent_we;
    logic [IW-1:0] ent_waddr;
    logic [71:0]   ent_wdata;
    logic [IW-1:0] ent_raddr;

    logic [2:0]    in_op;
    logic [9:0]    in_h;
    logic [XW-1:0] h_ext, hint_x, start_x, idx_x;
    logic          full_now, accept;
    logic [63:0]   avail, scan_mask;
    logic [5:0]    fbit, hb;
    logic          bit_used;

    assign in_op    = s_axis_tdata[2:0];
    assign in_h     = s_axis_tdata[12:3];
    assign h_ext    = XW'(in_h);
    assign hint_x   = XW'(r_hint);
    assign start_x  = (in_op == OP_ADD_AUTO && h_ext > hint_x) ? h_ext : hint_x;
    assign full_now = (XW'(r_used) + XW'(r_resv)) >= CAP_X;
    assign accept   = s_axis_tvalid && s_axis_tready;

    assign scan_mask = r_first ? ({64{1'b1}} << r_b) : {64{1'b1}};
    assign avail     = ~r_bm_q & scan_mask;
    assign fbit      = low_bit(avail);
    assign hb        = r_h[5:0];
    assign bit_used  = r_bm_q[hb];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign ent_raddr     = IW'({n_w, n_b});

    always_comb begin
        n_state = r_state;  n_w = r_w;  n_b = r_b;  n_first = r_first;
        n_op = r_op;  n_h = r_h;  n_right = r_right;
        n_obj = r_obj;  n_rts = r_rts;  n_flg = r_flg;  n_full = r_full;
        n_word = r_word;  n_hint = r_hint;  n_used = r_used;  n_resv = r_resv;
        n_pc = r_pc;  n_sta = r_sta;  n_hdl = r_hdl;  n_rep = r_rep;
        n_robj = r_robj;  n_rrts = r_rrts;  n_rflg = r_rflg;
        n_mvalid = r_mvalid;  n_mdata = r_mdata;
        bm_we = 1'b0;  bm_waddr = r_w;  bm_wdata = '0;
        ent_we = 1'b0;  ent_waddr = r_h;  ent_wdata = {r_flg, r_rts, r_obj};
        idx_x = '0;

        if (r_mvalid && m_axis_tready) n_mvalid = 1'b0;

        unique case (r_state)
            S_CLR: begin
                bm_we = 1'b1;
                if (r_w == LAST_WORD) begin
                    n_state = S_IDLE;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op = in_op;  n_h = IW'(h_ext);  n_right = s_axis_tdata[13];
                    n_obj = s_axis_tdata[45:14];  n_rts = s_axis_tdata[77:46];
                    n_flg = s_axis_tdata[85:78];  n_full = full_now;
                    n_sta = STAT_OK;  n_hdl = '0;  n_rep = 1'b0;
                    n_robj = '0;  n_rrts = '0;  n_rflg = '0;  n_pc = '0;
                    n_first = 1'b1;
                    unique case (in_op)
                        OP_ADD_AUTO, OP_ALLOC_RES: begin
                            n_w = WW'(start_x >> 6);
                            n_b = start_x[5:0];
                            if (in_op == OP_ALLOC_RES && r_resv == '0) begin
                                n_sta = STAT_BAD;  n_state = S_DONE;
                            end else if ((in_op == OP_ADD_AUTO && full_now)
                                         || start_x >= CAP_X) begin
                                n_sta = STAT_FULL;  n_state = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_ADD_AT, OP_REMOVE, OP_RESOLVE: begin
                            n_hdl = in_h;
                            n_w = WW'(h_ext >> 6);
                            n_b = in_h[5:0];
                            if (h_ext >= CAP_X) begin
                                n_sta = STAT_BAD;  n_state = S_DONE;
                            end else begin
                                n_state = S_HCHK;
                            end
                        end
                        OP_RESERVE: begin
                            if (full_now) n_sta = STAT_FULL;
                            else n_resv = r_resv + 1'b1;
                            n_state = S_DONE;
                        end
                        OP_UNRESERVE: begin
                            if (r_resv == '0) n_sta = STAT_BAD;
                            else n_resv = r_resv - 1'b1;
                            n_state = S_DONE;
                        end
                        OP_PURGE: begin
                            n_w = '0;
                            n_state = S_PLD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                n_first = 1'b0;
                idx_x = (XW'(r_w) << 6) | XW'(fbit);
                if (avail != '0) begin
                    n_state = S_DONE;
                    if (idx_x >= CAP_X) begin
                        n_sta = STAT_FULL;
                    end else begin
                        bm_we = 1'b1;
                        bm_wdata = r_bm_q | (64'd1 << fbit);
                        ent_we = 1'b1;
                        ent_waddr = IW'(idx_x);
                        n_used = r_used + 1'b1;
                        if (r_op == OP_ALLOC_RES) n_resv = r_resv - 1'b1;
                        if (idx_x == hint_x) n_hint = CW'(idx_x + 1'b1);
                        n_hdl = idx_x[9:0];
                    end
                end else if (r_w == LAST_WORD) begin
                    n_sta = STAT_FULL;  n_state = S_DONE;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            S_HCHK: begin
                n_state = S_DONE;
                idx_x = XW'(r_h);
                priority if (!bit_used) begin
                    if (r_op != OP_ADD_AT) begin
                        n_sta = STAT_BAD;
                    end else if (r_full) begin
                        n_sta = STAT_FULL;
                    end else begin
                        bm_we = 1'b1;  bm_wdata = r_bm_q | (64'd1 << hb);
                        ent_we = 1'b1;
                        n_used = r_used + 1'b1;
                        if (idx_x == hint_x) n_hint = CW'(idx_x + 1'b1);
                    end
                end else if (r_op == OP_ADD_AT && !r_right) begin
                    n_sta = STAT_BAD;
                end else begin
                    n_robj = r_ent_q[31:0];
                    n_rrts = r_ent_q[63:32];
                    n_rflg = r_ent_q[71:64];
                    if (r_op == OP_ADD_AT) begin
                        n_rep = 1'b1;
                        ent_we = 1'b1;
                        if (idx_x == hint_x) n_hint = CW'(idx_x + 1'b1);
                    end else if (r_op == OP_REMOVE) begin
                        bm_we = 1'b1;  bm_wdata = r_bm_q & ~(64'd1 << hb);
                        n_used = r_used - 1'b1;
                        if (idx_x < hint_x) n_hint = CW'(idx_x);
                    end
                end
            end
            S_PLD: begin
                n_word = r_bm_q;
                n_b = '0;
                n_state = S_PENT;
            end
            S_PENT: begin
                idx_x = (XW'(r_w) << 6) | XW'(r_b);
                // entry data for the current bit arrived from the read issued last cycle
                if (r_word[r_b] && (r_ent_q[71:64] & r_keep) == '0) begin
                    n_word = r_word & ~(64'd1 << r_b);
                    n_pc = r_pc + 1'b1;
                    n_used = r_used - 1'b1;
                    if (idx_x < hint_x) n_hint = CW'(idx_x);
                end
                if (r_b == 6'd63) n_state = S_PWB;
                else n_b = r_b + 1'b1;
            end
            S_PWB: begin
                bm_we = 1'b1;  bm_wdata = r_word;
                if (r_w == LAST_WORD) begin
                    n_state = S_DONE;
                end else begin
                    n_w = r_w + 1'b1;
                    n_state = S_PLD;
                end
            end
            S_DONE: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_mvalid = 1'b1;
                    n_mdata = {11'(r_pc), r_rflg, r_rrts, r_robj, r_rep, r_hdl, r_sta};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
        r_bm_q <= bm_mem[n_w];
        if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
        r_ent_q <= ent_mem[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_w      <= '0;
            r_hint   <= '0;
            r_used   <= '0;
            r_resv   <= '0;
            r_mvalid <= 1'b0;
            r_keep   <= KEEP_MASK_RESET;
        end else begin
            r_state  <= n_state;
            r_w      <= n_w;
            r_hint   <= n_hint;
            r_used   <= n_used;
            r_resv   <= n_resv;
            r_mvalid <= n_mvalid;
            if (i_cfg_wr_en) r_keep <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b <= n_b;  r_first <= n_first;  r_op <= n_op;  r_h <= n_h;
        r_right <= n_right;  r_obj <= n_obj;  r_rts <= n_rts;  r_flg <= n_flg;
        r_full <= n_full;  r_word <= n_word;  r_pc <= n_pc;  r_sta <= n_sta;
        r_hdl <= n_hdl;  r_rep <= n_rep;  r_robj <= n_robj;  r_rrts <= n_rrts;
        r_rflg <= n_rflg;  r_mdata <= n_mdata;
    end

endmodule

### sv/hta_checker.sv
// port-level checks for the handle table allocator, bound to the top level
`timescale 1ns / 1ps

module hta_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [hta_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import hta_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one word in flight: the sequencer is busy right after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while busy");

    // an error result carries no entry contents and no purge count
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != STAT_OK |->
            m_axis_tdata[95:12] == '0)
        else $error("error result carries entry data");

    // a replacement is only reported on success and never with a purge count
    a_rep_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[1:0] == STAT_OK
            && m_axis_tdata[95:85] == '0)
        else $error("replaced set on a failed or purge result");

endmodule

bind handle_table_allocator hta_checker u_hta_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb.sv
// testbench for the handle table allocator: directed and random operation words
`timescale 1ns / 1ps

module tb;
    import hta_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int WORDS_LAT = 20;
    localparam int LONG_STALL = 400;

    // first member sits in the top bits, so the field order is reversed here
    typedef struct packed {
        logic [10:0] purged;
        logic [7:0]  flags;
        logic [31:0] rights;
        logic [31:0] obj;
        logic        replaced;
        logic [9:0]  handle;
        logic [1:0]  status;
    } t_answer;

    class t_answer_board;
        t_answer pending[$];
        int mismatches = 0;
        int checked = 0;

        function void note(t_answer a);
            pending.push_back(a);
        endfunction

        function void check(t_answer got);
            t_answer want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st=%0d h=%0d r=%0d o=%h ri=%h f=%h p=%0d",
                             want.status, want.handle, want.replaced, want.obj,
                             want.rights, want.flags, want.purged,
                             " got st=%0d h=%0d r=%0d o=%h ri=%h f=%h p=%0d",
                             got.status, got.handle, got.replaced, got.obj,
                             got.rights, got.flags, got.purged);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_wr_en = 0;
    logic [7:0] i_cfg_wr_data = 0;
    logic s_axis_tvalid = 0, s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid, m_axis_tready = 0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    handle_table_allocator u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [63:0] occ [16];
    logic [31:0] objs [CAP];
    logic [31:0] rts [CAP];
    logic [7:0]  fls [CAP];
    int hint, used, reserved;
    logic [7:0] keep;
    int op_seen [8];

    t_answer_board board = new();
    int cycles = 0;
    int hold_off = 0;
    bit stall_req = 0;
    bit stall_taken = 0;
    bit done = 0;

    function automatic bit occupied(int h);
        return occ[h >> 6][h & 63];
    endfunction

    function automatic int lowest_free(int start);
        for (int i = start; i < CAP; i++) if (!occupied(i)) return i;
        return CAP;
    endfunction

    function automatic void store(int h, logic [31:0] o, logic [31:0] r, logic [7:0] f);
        occ[h >> 6][h & 63] = 1;
        if (h == hint) hint = h + 1;
        objs[h] = o; rts[h] = r; fls[h] = f;
    endfunction

    function automatic t_answer predict(logic [2:0] op, int h, bit right,
                                        logic [31:0] o, logic [31:0] r, logic [7:0] f);
        t_answer a;
        bit full;
        int idx;
        a = '0;
        full = (used + reserved >= CAP);
        case (op)
            OP_ADD_AUTO: begin
                idx = lowest_free(h > hint ? h : hint);
                if (idx >= CAP || full) a.status = STAT_FULL;
                else begin store(idx, o, r, f); used++; a.handle = 10'(idx); end
            end
            OP_ADD_AT: begin
                a.handle = 10'(h);
                if (occupied(h)) begin
                    if (!right) a.status = STAT_BAD;
                    else begin
                        a.obj = objs[h]; a.rights = rts[h]; a.flags = fls[h];
                        a.replaced = 1;
                        store(h, o, r, f);
                    end
                end else if (full) a.status = STAT_FULL;
                else begin store(h, o, r, f); used++; end
            end
            OP_RESERVE: if (full) a.status = STAT_FULL; else reserved++;
            OP_UNRESERVE: if (reserved == 0) a.status = STAT_BAD; else reserved--;
            OP_ALLOC_RES: begin
                if (reserved == 0) a.status = STAT_BAD;
                else begin
                    idx = lowest_free(hint);
                    if (idx >= CAP) a.status = STAT_FULL;
                    else begin
                        store(idx, o, r, f); used++; reserved--; a.handle = 10'(idx);
                    end
                end
            end
            OP_REMOVE: begin
                a.handle = 10'(h);
                if (!occupied(h)) a.status = STAT_BAD;
                else begin
                    a.obj = objs[h]; a.rights = rts[h]; a.flags = fls[h];
                    occ[h >> 6][h & 63] = 0;
                    if (h < hint) hint = h;
                    used--;
                end
            end
            OP_RESOLVE: begin
                a.handle = 10'(h);
                if (!occupied(h)) a.status = STAT_BAD;
                else begin a.obj = objs[h]; a.rights = rts[h]; a.flags = fls[h]; end
            end
            default: begin
                for (int i = 0; i < CAP; i++)
                    if (occupied(i) && (fls[i] & keep) == 0) begin
                        occ[i >> 6][i & 63] = 0;
                        if (i < hint) hint = i;
                        used--;
                        a.purged++;
                    end
            end
        endcase
        return a;
    endfunction

    // sends one word; the expectation is noted as the word is accepted
    task automatic send_word(logic [2:0] op, int h, bit right,
                             logic [31:0] o, logic [31:0] r, logic [7:0] f,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, f, r, o, right, h[9:0], op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note(predict(op, h, right, o, r, f));
        op_seen[op]++;
    endtask

    task automatic idle_drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (WORDS_LAT) @(posedge i_clk);
    endtask

    task automatic write_keep(logic [7:0] v);
        idle_drain();
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        keep = v;
    endtask

    // random operation mix, biased so the table gets busy
    task automatic random_word();
        int sel, h;
        logic [2:0] op;
        sel = $urandom_range(0, 99);
        if (sel < 30) op = OP_ADD_AUTO;
        else if (sel < 42) op = OP_ADD_AT;
        else if (sel < 50) op = OP_RESERVE;
        else if (sel < 55) op = OP_UNRESERVE;
        else if (sel < 62) op = OP_ALLOC_RES;
        else if (sel < 80) op = OP_REMOVE;
        else if (sel < 99) op = OP_RESOLVE;
        else op = OP_PURGE;
        h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
        send_word(op, h, 1'($urandom_range(0, 1)), $urandom, $urandom,
                  8'($urandom_range(0, 255)));
    endtask

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata);
        if (stall_req && !stall_taken) begin
            stall_taken <= 1;
            hold_off <= LONG_STALL;
            m_axis_tready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        if (cycles >= LIMIT_CYCLES && !done) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int w = 0; w < 16; w++) occ[w] = '0;
        hint = 0; used = 0; reserved = 0; keep = KEEP_MASK_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes and special cases
        send_word(OP_UNRESERVE, 0, 0, 0, 0, 0);
        send_word(OP_ALLOC_RES, 0, 0, 1, 1, 1);
        send_word(OP_REMOVE, 1023, 0, 0, 0, 0);
        send_word(OP_RESOLVE, 0, 0, 0, 0, 0);
        send_word(OP_ADD_AUTO, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_ADD_AUTO, 1023, 1, 32'h0, 32'h0, 8'h00);
        send_word(OP_ADD_AUTO, 1020, 0, 32'h1234, 32'h5678, 8'h02);
        send_word(OP_ADD_AT, 1023, 0, 5, 6, 7);
        send_word(OP_ADD_AT, 1023, 1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h81);
        send_word(OP_ADD_AT, 64, 1, 9, 9, 8'h04);
        send_word(OP_RESERVE, 0, 0, 0, 0, 0);
        send_word(OP_ALLOC_RES, 0, 0, 3, 3, 8'h01);
        send_word(OP_RESERVE, 0, 0, 0, 0, 0);
        send_word(OP_PURGE, 0, 0, 0, 0, 0);
        send_word(OP_UNRESERVE, 0, 0, 0, 0, 0);
        send_word(OP_RESOLVE, 1023, 0, 0, 0, 0);
        send_word(OP_REMOVE, 1023, 0, 0, 0, 0);
        send_word(OP_REMOVE, 1023, 0, 0, 0, 0);

        // fill the table to the brim, then hit the full cases
        write_keep(8'hFF);
        for (int i = 0; i < CAP; i++)
            send_word(OP_ADD_AUTO, 0, 0, $urandom, $urandom, 8'(i),
                      $urandom_range(0, 3) != 0);
        send_word(OP_ADD_AUTO, 0, 0, 1, 1, 1);
        send_word(OP_RESERVE, 0, 0, 0, 0, 0);
        send_word(OP_REMOVE, 500, 0, 0, 0, 0);
        send_word(OP_RESERVE, 0, 0, 0, 0, 0);
        send_word(OP_ADD_AT, 500, 0, 1, 1, 1);
        send_word(OP_ALLOC_RES, 0, 0, 2, 2, 2);
        send_word(OP_PURGE, 0, 0, 0, 0, 0);
        write_keep(8'h00);
        send_word(OP_PURGE, 0, 0, 0, 0, 0);

        // random phases across keep mask settings
        for (int ph = 0; ph < 4; ph++) begin
            write_keep(ph == 0 ? 8'h01 : ph == 3 ? 8'h80 : 8'($urandom));
            if (ph == 1) stall_req = 1;
            for (int n = 0; n < 20; n++) random_word();
            if (ph == 2) idle_drain();
        end

        idle_drain();
        done = 1;
        $display("ran %0d checked words; op counts %0d %0d %0d %0d %0d %0d %0d %0d",
                 board.checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3],
                 op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
        $display("table filled to capacity, keep mask swept from none to all bits");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### files.f
sv/hta_pkg.sv
sv/handle_table_allocator.sv
sv/hta_checker.sv
tb/sv/tb.sv
